>>> rtl/spw_pkg.sv
// ----------------------------------------------------------------------------
// spw_pkg
// Shared types and constants of the stage progress watchdog.
// ----------------------------------------------------------------------------
package spw_pkg;

  localparam int TIME_BITS_DEF = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STAGE_W    = 4;
  localparam int FUNC_W     = 3;
  localparam int STUCK_W    = 32;

  localparam logic [CFG_DATA_W-1:0] SAMPLE_PERIOD_RST = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] STUCK_LIMIT_RST   = 16'd3000;
  localparam logic [CFG_DATA_W-1:0] RESTFUL_MASK_RST  = 16'd17;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK      = 3'd0,
    FN_HEARTBEAT = 3'd1,
    FN_SET_STAGE = 3'd2,
    FN_DONE      = 3'd3,
    FN_SET_ARMED = 3'd4
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_PERIOD = 2'd0,
    CFG_STUCK_LIMIT   = 2'd1,
    CFG_RESTFUL_MASK  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [STAGE_W-1:0] stage;
    logic               arm_value;
  } item_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] sample_period;
    logic [CFG_DATA_W-1:0] stuck_limit;
    logic [CFG_DATA_W-1:0] restful_mask;
  } cfg_t;

endpackage

>>> rtl/spw_ifs.sv
// ----------------------------------------------------------------------------
// spw_ifs
// Valid/ready channels for watchdog events and watchdog results.
// ----------------------------------------------------------------------------
interface spw_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [3:0] stage;
  logic       arm_value;

  modport source (output valid, output func, output stage, output arm_value, input ready);
  modport sink   (input valid, input func, input stage, input arm_value, output ready);
endinterface

interface spw_out_if;
  logic        valid;
  logic        ready;
  logic        fired;
  logic        sampled;
  logic [31:0] stuck_time;
  logic [3:0]  fire_stage;

  modport source (output valid, output fired, output sampled, output stuck_time,
                  output fire_stage, input ready);
  modport sink   (input valid, input fired, input sampled, input stuck_time,
                  input fire_stage, output ready);
endinterface

>>> rtl/spw_cfg_regs.sv
// ----------------------------------------------------------------------------
// spw_cfg_regs
// Configuration registers: sample period, stuck limit, restful stage mask.
// ----------------------------------------------------------------------------
module spw_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [spw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output spw_pkg::cfg_t                  cfg
);
  import spw_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_PERIOD: cfg_nxt.sample_period = cfg_wdata;
        CFG_STUCK_LIMIT:   cfg_nxt.stuck_limit   = cfg_wdata;
        CFG_RESTFUL_MASK:  cfg_nxt.restful_mask  = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_period <= SAMPLE_PERIOD_RST;
      cfg_r.stuck_limit   <= STUCK_LIMIT_RST;
      cfg_r.restful_mask  <= RESTFUL_MASK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/spw_in_stage.sv
// ----------------------------------------------------------------------------
// spw_in_stage
// Input register for one event; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module spw_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  spw_pkg::item_t in_item,
  input  logic           take,
  output logic           s1_valid,
  output spw_pkg::item_t s1_item
);
  import spw_pkg::*;

  logic  s1_valid_r;
  logic  s1_valid_nxt;
  item_t s1_item_r;

  assign in_ready = !s1_valid_r || take;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload: load on every transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

>>> rtl/spw_core.sv
// ----------------------------------------------------------------------------
// spw_core
// Watchdog state, per-event update and progress sampling, result register.
// ----------------------------------------------------------------------------
module spw_core #(
  parameter int TIME_BITS = spw_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  input  spw_pkg::item_t               item,
  input  spw_pkg::cfg_t                cfg,
  output logic                         take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_fired,
  output logic                         out_sampled,
  output logic [spw_pkg::STUCK_W-1:0]  out_stuck_time,
  output logic [spw_pkg::STAGE_W-1:0]  out_fire_stage
);
  import spw_pkg::*;

  logic [TIME_BITS-1:0]  now_r, now_nxt;
  logic [TIME_BITS-1:0]  hb_r, hb_nxt;
  logic [STAGE_W-1:0]    stage_r, stage_nxt;
  logic [TIME_BITS-1:0]  since_r, since_nxt;
  logic [TIME_BITS-1:0]  snap_hb_r, snap_hb_nxt;
  logic [STAGE_W-1:0]    snap_stage_r, snap_stage_nxt;
  logic [TIME_BITS-1:0]  snap_since_r, snap_since_nxt;
  logic [CFG_DATA_W-1:0] cnt_r, cnt_nxt;
  logic                  armed_r, armed_nxt;
  logic                  fired_r, fired_nxt;
  logic [STUCK_W-1:0]    stuck_r, stuck_nxt;
  logic [STAGE_W-1:0]    fstage_r, fstage_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  res_fired_r, res_sampled_r;
  logic [STUCK_W-1:0]    res_stuck_r;
  logic [STAGE_W-1:0]    res_fstage_r;

  logic                  adv;
  logic [TIME_BITS-1:0]  now_inc;
  logic [CFG_DATA_W-1:0] cnt_inc;
  logic [CFG_DATA_W-1:0] period;
  logic                  hit;
  logic                  same;
  logic                  restful;
  logic [TIME_BITS-1:0]  age;
  logic [63:0]           age_w;
  logic [STUCK_W-1:0]    age_sat;
  logic                  stuck;
  logic                  sampled;

  assign take = !out_valid_r || out_ready;
  assign adv  = item_valid && take;

  // shared datapath for the sample taken on a tick
  always_comb begin
    now_inc = (now_r != {TIME_BITS{1'b1}}) ? now_r + 1'b1 : now_r;
    cnt_inc = cnt_r + 1'b1;
    period  = (cfg.sample_period == '0) ? CFG_DATA_W'(1) : cfg.sample_period;
    hit     = (cnt_inc >= period) || (cnt_inc == '0);
    same    = (hb_r == snap_hb_r) && (stage_r == snap_stage_r) && (since_r == snap_since_r);
    restful = cfg.restful_mask[stage_r];
    age     = (now_inc >= hb_r) ? now_inc - hb_r : '0;
    age_w   = 64'(age);
    age_sat = (age_w[63:32] != '0) ? {STUCK_W{1'b1}} : age_w[31:0];
    stuck   = same && !restful && (age >= TIME_BITS'(cfg.stuck_limit));
  end

  always_comb begin
    now_nxt        = now_r;
    hb_nxt         = hb_r;
    stage_nxt      = stage_r;
    since_nxt      = since_r;
    snap_hb_nxt    = snap_hb_r;
    snap_stage_nxt = snap_stage_r;
    snap_since_nxt = snap_since_r;
    cnt_nxt        = cnt_r;
    armed_nxt      = armed_r;
    fired_nxt      = fired_r;
    stuck_nxt      = stuck_r;
    fstage_nxt     = fstage_r;
    sampled        = 1'b0;
    unique case (item.func)
      FN_TICK: begin
        now_nxt = now_inc;
        if (armed_r && !fired_r) begin
          cnt_nxt = hit ? '0 : cnt_inc;
          if (hit) begin
            sampled = 1'b1;
            if (stuck) begin
              fired_nxt  = 1'b1;
              stuck_nxt  = age_sat;
              fstage_nxt = stage_r;
            end else begin
              // advance the snapshot
              snap_hb_nxt    = hb_r;
              snap_stage_nxt = stage_r;
              snap_since_nxt = since_r;
            end
          end
        end
      end
      FN_HEARTBEAT: begin
        hb_nxt    = now_r;
        since_nxt = now_r;
      end
      FN_SET_STAGE: begin
        stage_nxt = item.stage;
        since_nxt = now_r;
      end
      FN_DONE: begin
        hb_nxt    = now_r;
        stage_nxt = '0;
        since_nxt = now_r;
      end
      FN_SET_ARMED: begin
        armed_nxt = item.arm_value;
        cnt_nxt   = '0;
      end
      default: begin
        now_nxt = now_r;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r        <= '0;
      hb_r         <= '0;
      stage_r      <= '0;
      since_r      <= '0;
      snap_hb_r    <= '0;
      snap_stage_r <= '0;
      snap_since_r <= '0;
      cnt_r        <= '0;
      armed_r      <= 1'b0;
      fired_r      <= 1'b0;
      stuck_r      <= '0;
      fstage_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (adv) begin
        now_r        <= now_nxt;
        hb_r         <= hb_nxt;
        stage_r      <= stage_nxt;
        since_r      <= since_nxt;
        snap_hb_r    <= snap_hb_nxt;
        snap_stage_r <= snap_stage_nxt;
        snap_since_r <= snap_since_nxt;
        cnt_r        <= cnt_nxt;
        armed_r      <= armed_nxt;
        fired_r      <= fired_nxt;
        stuck_r      <= stuck_nxt;
        fstage_r     <= fstage_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload: hold until the next event is taken
  always_ff @(posedge clk) begin
    if (adv) begin
      res_fired_r   <= fired_nxt;
      res_sampled_r <= sampled;
      res_stuck_r   <= stuck_nxt;
      res_fstage_r  <= fstage_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_fired      = res_fired_r;
  assign out_sampled    = res_sampled_r;
  assign out_stuck_time = res_stuck_r;
  assign out_fire_stage = res_fstage_r;

endmodule

>>> rtl/stage_progress_watchdog_top.sv
// ----------------------------------------------------------------------------
// stage_progress_watchdog_top
// Sampling progress watchdog over heartbeat, stage and tick events.
// ----------------------------------------------------------------------------
// Every event gives exactly one result: an input register takes the event and
// the state update writes its outcome to a result register. One event is taken
// per clock while the result side is ready, and the two registers drain and
// refill in the same cycle, so a stalled result holds at most one more event.
// The tick path (saturating time increment, heartbeat age subtract and
// stuck-limit compare) sets the clock period. No clearing pass is needed after
// reset.
module stage_progress_watchdog_top #(
  parameter int TIME_BITS = spw_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  spw_in_if.sink                         in_ch,
  spw_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [spw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import spw_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  take;

  assign in_item.func      = in_ch.func;
  assign in_item.stage     = in_ch.stage;
  assign in_item.arm_value = in_ch.arm_value;

  spw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  spw_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  spw_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (s1_valid),
    .item           (s1_item),
    .cfg            (cfg),
    .take           (take),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_fired      (out_ch.fired),
    .out_sampled    (out_ch.sampled),
    .out_stuck_time (out_ch.stuck_time),
    .out_fire_stage (out_ch.fire_stage)
  );

endmodule

>>> rtl/spw_checker.sv
// ----------------------------------------------------------------------------
// spw_checker
// Port-level checks of the watchdog, bound to the top level.
// ----------------------------------------------------------------------------
module spw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_fired,
  input logic out_sampled
);

  logic out_xfer;
  logic seen_fired_r;
  logic seen_fired_nxt;

  assign out_xfer = out_valid && out_ready;

  always_comb begin
    seen_fired_nxt = seen_fired_r;
    if (out_xfer && out_fired) begin
      seen_fired_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_fired_r <= 1'b0;
    end else begin
      seen_fired_r <= seen_fired_nxt;
    end
  end

  // hold a pending result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // fired is sticky across results
  a_fired_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && seen_fired_r |-> out_fired)
    else $error("fired flag cleared");

  // a fired watchdog takes no more samples
  a_no_sample_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && seen_fired_r |-> !out_sampled)
    else $error("sample after firing");

  // an empty result register never backs up the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // an event taken while no result is pending is answered through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |-> ##2 out_valid)
    else $error("result missing after event");

endmodule

bind stage_progress_watchdog_top spw_checker u_spw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_fired   (out_ch.fired),
  .out_sampled (out_ch.sampled)
);
